>>> hdl/aizrk_pkg.sv
`default_nettype none
package aizrk_pkg;

  localparam int unsigned ValueWidth = 32;
  localparam int unsigned FracBits   = 24;

  localparam logic signed [ValueWidth-1:0] OneFx   = ValueWidth'(64'sd1 <<< FracBits);
  localparam logic signed [ValueWidth-1:0] ThirdFx = ValueWidth'(((64'sd1 <<< FracBits) + 1) / 3);
  localparam logic signed [ValueWidth-1:0] SixthFx = ValueWidth'(((64'sd1 <<< FracBits) + 3) / 6);
  localparam logic signed [ValueWidth-1:0] HalfFx  = ValueWidth'((64'sd1 <<< FracBits) / 2);

  // register indexes on the configuration port
  localparam logic [2:0] RG_A    = 3'd0;
  localparam logic [2:0] RG_B    = 3'd1;
  localparam logic [2:0] RG_C    = 3'd2;
  localparam logic [2:0] RG_D    = 3'd3;
  localparam logic [2:0] RG_E    = 3'd4;
  localparam logic [2:0] RG_F    = 3'd5;
  localparam logic [2:0] RG_STEP = 3'd6;

  // operations
  localparam logic [1:0] OP_ADD = 2'd0;
  localparam logic [1:0] OP_SUB = 2'd1;
  localparam logic [1:0] OP_MUL = 2'd2;

  // operand codes: below 32 scratch memory, above constants and registers
  localparam logic [5:0] SX = 6'd0,  SY = 6'd1,  SZ = 6'd2;
  localparam logic [5:0] KX = 6'd3,  KY = 6'd4,  KZ = 6'd5;
  localparam logic [5:0] AX = 6'd6,  AY = 6'd7,  AZ = 6'd8;
  localparam logic [5:0] HH = 6'd9,  H6 = 6'd10;
  localparam logic [5:0] ZB = 6'd11, T1 = 6'd12, T2 = 6'd13;
  localparam logic [5:0] Z2 = 6'd14, Z3 = 6'd15, R2 = 6'd16;
  localparam logic [5:0] EZ = 6'd17, TT = 6'd18;
  localparam logic [5:0] C_ZERO  = 6'd32, C_ONE = 6'd33, C_THIRD = 6'd34;
  localparam logic [5:0] C_SIXTH = 6'd35, C_HALF = 6'd36;
  localparam logic [5:0] C_A = 6'd37, C_B = 6'd38, C_C = 6'd39;
  localparam logic [5:0] C_D = 6'd40, C_E = 6'd41, C_F = 6'd42, C_H = 6'd43;
  localparam logic [5:0] PX = 6'd44, PY = 6'd45, PZ = 6'd46;

  // program segments
  localparam logic [2:0] SG_INIT  = 3'd0;
  localparam logic [2:0] SG_DERIV = 3'd1;
  localparam logic [2:0] SG_ACC1  = 3'd2;
  localparam logic [2:0] SG_ACC2  = 3'd3;
  localparam logic [2:0] SG_ACC4  = 3'd4;
  localparam logic [2:0] SG_ADVH  = 3'd5;
  localparam logic [2:0] SG_ADVF  = 3'd6;
  localparam logic [2:0] SG_FIN   = 3'd7;

  localparam logic [3:0] LAST_POS = 4'd12;

  typedef struct packed {
    logic [1:0] op;
    logic [5:0] dst;
    logic [5:0] src_a;
    logic [5:0] src_b;
  } uop_t;

  typedef struct packed {
    logic rd;
    logic ex;
    logic wb;
    uop_t uop;
  } ctrl_cmd_t;

  typedef struct packed {
    logic signed [ValueWidth-1:0] a;
    logic signed [ValueWidth-1:0] b;
    logic signed [ValueWidth-1:0] c;
    logic signed [ValueWidth-1:0] d;
    logic signed [ValueWidth-1:0] e;
    logic signed [ValueWidth-1:0] f;
    logic signed [ValueWidth-1:0] h;
  } coef_t;

  typedef struct packed {
    logic signed [ValueWidth-1:0] x;
    logic signed [ValueWidth-1:0] y;
    logic signed [ValueWidth-1:0] z;
  } pos_t;

  function automatic uop_t mk(logic [1:0] op, logic [5:0] d, logic [5:0] a, logic [5:0] b);
    uop_t u;
    u.op = op;
    u.dst = d;
    u.src_a = a;
    u.src_b = b;
    return u;
  endfunction

  function automatic logic [2:0] seg_at(logic [3:0] p);
    logic [2:0] s;
    case (p)
      4'd0:    s = SG_INIT;
      4'd1:    s = SG_DERIV;
      4'd2:    s = SG_ACC1;
      4'd3:    s = SG_ADVH;
      4'd4:    s = SG_DERIV;
      4'd5:    s = SG_ACC2;
      4'd6:    s = SG_ADVH;
      4'd7:    s = SG_DERIV;
      4'd8:    s = SG_ACC2;
      4'd9:    s = SG_ADVF;
      4'd10:   s = SG_DERIV;
      4'd11:   s = SG_ACC4;
      default: s = SG_FIN;
    endcase
    return s;
  endfunction

  function automatic logic [4:0] seg_last(logic [2:0] s);
    logic [4:0] n;
    case (s)
      SG_INIT:  n = 5'd4;
      SG_DERIV: n = 5'd22;
      SG_ACC1:  n = 5'd2;
      SG_ACC4:  n = 5'd2;
      default:  n = 5'd5;
    endcase
    return n;
  endfunction

  function automatic uop_t deriv_op(logic [4:0] i);
    uop_t u;
    case (i)
      5'd0:    u = mk(OP_SUB, ZB, SZ, C_B);
      5'd1:    u = mk(OP_MUL, T1, ZB, SX);
      5'd2:    u = mk(OP_MUL, T2, C_D, SY);
      5'd3:    u = mk(OP_SUB, KX, T1, T2);
      5'd4:    u = mk(OP_MUL, T1, C_D, SX);
      5'd5:    u = mk(OP_MUL, T2, ZB, SY);
      5'd6:    u = mk(OP_ADD, KY, T1, T2);
      5'd7:    u = mk(OP_MUL, Z2, SZ, SZ);
      5'd8:    u = mk(OP_MUL, Z3, Z2, SZ);
      5'd9:    u = mk(OP_MUL, T1, SX, SX);
      5'd10:   u = mk(OP_MUL, T2, SY, SY);
      5'd11:   u = mk(OP_ADD, R2, T1, T2);
      5'd12:   u = mk(OP_MUL, T1, C_E, SZ);
      5'd13:   u = mk(OP_ADD, EZ, C_ONE, T1);
      5'd14:   u = mk(OP_MUL, T1, C_A, SZ);
      5'd15:   u = mk(OP_ADD, TT, C_C, T1);
      5'd16:   u = mk(OP_MUL, T1, Z3, C_THIRD);
      5'd17:   u = mk(OP_SUB, TT, TT, T1);
      5'd18:   u = mk(OP_MUL, T1, R2, EZ);
      5'd19:   u = mk(OP_SUB, TT, TT, T1);
      5'd20:   u = mk(OP_MUL, T1, C_F, SX);
      5'd21:   u = mk(OP_MUL, T2, T1, SZ);
      default: u = mk(OP_ADD, KZ, TT, T2);
    endcase
    return u;
  endfunction

  function automatic uop_t prog_op(logic [2:0] s, logic [4:0] i);
    uop_t u;
    logic [5:0] k, ac, ss, pp;
    k  = 6'(KX + 6'(i >> 1));
    ac = 6'(AX + 6'(i >> 1));
    ss = 6'(SX + 6'(i >> 1));
    pp = 6'(PX + 6'(i >> 1));
    case (s)
      SG_INIT: begin
        case (i)
          5'd0:    u = mk(OP_MUL, HH, C_HALF, C_H);
          5'd1:    u = mk(OP_MUL, H6, C_H, C_SIXTH);
          5'd2:    u = mk(OP_ADD, SX, PX, C_ZERO);
          5'd3:    u = mk(OP_ADD, SY, PY, C_ZERO);
          default: u = mk(OP_ADD, SZ, PZ, C_ZERO);
        endcase
      end
      SG_DERIV: u = deriv_op(i);
      SG_ACC1:  u = mk(OP_ADD, 6'(AX + 6'(i)), 6'(KX + 6'(i)), C_ZERO);
      SG_ACC4:  u = mk(OP_ADD, 6'(AX + 6'(i)), 6'(AX + 6'(i)), 6'(KX + 6'(i)));
      SG_ACC2:  u = i[0] ? mk(OP_ADD, ac, ac, T1) : mk(OP_ADD, T1, k, k);
      SG_ADVH:  u = i[0] ? mk(OP_ADD, ss, pp, T1) : mk(OP_MUL, T1, HH, k);
      SG_ADVF:  u = i[0] ? mk(OP_ADD, ss, pp, T1) : mk(OP_MUL, T1, C_H, k);
      default:  u = i[0] ? mk(OP_ADD, pp, pp, T1) : mk(OP_MUL, T1, H6, ac);
    endcase
    return u;
  endfunction

endpackage
`default_nettype wire

>>> hdl/aizrk_if.sv
`default_nettype none
interface aizrk_in_if;
  logic               valid;
  logic               ready;
  logic               restart;
  logic signed [31:0] start_x;
  logic signed [31:0] start_y;
  logic signed [31:0] start_z;
  modport source(output valid, restart, start_x, start_y, start_z, input ready);
  modport sink(input valid, restart, start_x, start_y, start_z, output ready);
endinterface

interface aizrk_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] out_x;
  logic signed [31:0] out_y;
  logic signed [31:0] out_z;
  modport source(output valid, out_x, out_y, out_z, input ready);
  modport sink(input valid, out_x, out_y, out_z, output ready);
endinterface
`default_nettype wire

>>> hdl/aizrk_datapath.sv
`default_nettype none
module aizrk_datapath import aizrk_pkg::*; (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire ctrl_cmd_t               cmd_i,
  input  wire coef_t                   coef_i,
  input  wire logic                    load_i,
  input  wire logic signed [ValueWidth-1:0] start_x_i,
  input  wire logic signed [ValueWidth-1:0] start_y_i,
  input  wire logic signed [ValueWidth-1:0] start_z_i,
  output pos_t                         pos_o
);

  localparam logic signed [ValueWidth-1:0] MaxFx = {1'b0, {(ValueWidth-1){1'b1}}};
  localparam logic signed [ValueWidth-1:0] MinFx = {1'b1, {(ValueWidth-1){1'b0}}};

  logic signed [ValueWidth-1:0] mem_q [32];
  logic signed [ValueWidth-1:0] mrd_a_q, mrd_b_q, kst_a_q, kst_b_q;
  logic                         sel_a_q, sel_b_q;
  logic [1:0]                   op_q;
  logic [5:0]                   dst_q;
  logic [2*ValueWidth-1:0]      prod_q;
  logic                         neg_q;
  logic signed [ValueWidth:0]   sum_q;
  logic signed [ValueWidth-1:0] px_q, py_q, pz_q;

  logic signed [ValueWidth-1:0] opa, opb, res, mul_res, add_res;
  logic [ValueWidth-1:0]        mag_a, mag_b;
  logic [2*ValueWidth:0]        rnd;
  logic [ValueWidth+8:0]        quo, lim;

  function automatic logic signed [ValueWidth-1:0] src_val(logic [5:0] c, coef_t k,
      logic signed [ValueWidth-1:0] x, logic signed [ValueWidth-1:0] y,
      logic signed [ValueWidth-1:0] z);
    logic signed [ValueWidth-1:0] v;
    case (c)
      C_ONE:   v = OneFx;
      C_THIRD: v = ThirdFx;
      C_SIXTH: v = SixthFx;
      C_HALF:  v = HalfFx;
      C_A:     v = k.a;
      C_B:     v = k.b;
      C_C:     v = k.c;
      C_D:     v = k.d;
      C_E:     v = k.e;
      C_F:     v = k.f;
      C_H:     v = k.h;
      PX:      v = x;
      PY:      v = y;
      PZ:      v = z;
      default: v = '0;
    endcase
    return v;
  endfunction

  // operand fetch, and write back to scratch memory
  always_ff @(posedge clk_i) begin
    if (cmd_i.rd) begin
      mrd_a_q <= mem_q[cmd_i.uop.src_a[4:0]];
      mrd_b_q <= mem_q[cmd_i.uop.src_b[4:0]];
      kst_a_q <= src_val(cmd_i.uop.src_a, coef_i, px_q, py_q, pz_q);
      kst_b_q <= src_val(cmd_i.uop.src_b, coef_i, px_q, py_q, pz_q);
      sel_a_q <= cmd_i.uop.src_a[5];
      sel_b_q <= cmd_i.uop.src_b[5];
      op_q    <= cmd_i.uop.op;
      dst_q   <= cmd_i.uop.dst;
    end
    if (cmd_i.wb && !dst_q[5]) begin
      mem_q[dst_q[4:0]] <= res;
    end
  end

  assign opa   = sel_a_q ? kst_a_q : mrd_a_q;
  assign opb   = sel_b_q ? kst_b_q : mrd_b_q;
  assign mag_a = opa[ValueWidth-1] ? (~opa + 1'b1) : opa;
  assign mag_b = opb[ValueWidth-1] ? (~opb + 1'b1) : opb;

  // multiply on magnitudes, add and subtract one bit wider
  always_ff @(posedge clk_i) begin
    if (cmd_i.ex) begin
      prod_q <= mag_a * mag_b;
      neg_q  <= opa[ValueWidth-1] ^ opb[ValueWidth-1];
      if (op_q == OP_SUB) begin
        sum_q <= (ValueWidth+1)'(opa) - (ValueWidth+1)'(opb);
      end else begin
        sum_q <= (ValueWidth+1)'(opa) + (ValueWidth+1)'(opb);
      end
    end
  end

  // round half away from zero on the magnitude, then saturate
  assign rnd = {1'b0, prod_q} + ((2*ValueWidth+1)'(1) << (FracBits - 1));
  assign quo = (ValueWidth+9)'(rnd >> FracBits);
  assign lim = neg_q ? ((ValueWidth+9)'(1) << (ValueWidth - 1))
                     : (ValueWidth+9)'(MaxFx);

  always_comb begin
    if (quo > lim) begin
      mul_res = neg_q ? MinFx : MaxFx;
    end else if (neg_q) begin
      mul_res = ~quo[ValueWidth-1:0] + 1'b1;
    end else begin
      mul_res = quo[ValueWidth-1:0];
    end
    if (sum_q[ValueWidth] != sum_q[ValueWidth-1]) begin
      add_res = sum_q[ValueWidth] ? MinFx : MaxFx;
    end else begin
      add_res = sum_q[ValueWidth-1:0];
    end
    res = (op_q == OP_MUL) ? mul_res : add_res;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      px_q <= ValueWidth'(((64'sd1 <<< FracBits) + 5) / 10);
      py_q <= '0;
      pz_q <= '0;
    end else if (load_i) begin
      px_q <= start_x_i;
      py_q <= start_y_i;
      pz_q <= start_z_i;
    end else if (cmd_i.wb) begin
      if (dst_q == PX) px_q <= res;
      if (dst_q == PY) py_q <= res;
      if (dst_q == PZ) pz_q <= res;
    end
  end

  assign pos_o.x = px_q;
  assign pos_o.y = py_q;
  assign pos_o.z = pz_q;

endmodule
`default_nettype wire

>>> hdl/aizrk_controller.sv
`default_nettype none
module aizrk_controller import aizrk_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic start_i,
  output logic      idle_o,
  output ctrl_cmd_t cmd_o
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RD   = 2'd1;
  localparam logic [1:0] ST_EX   = 2'd2;
  localparam logic [1:0] ST_WB   = 2'd3;

  logic [1:0] state_q, state_d;
  logic [3:0] pos_q, pos_d;
  logic [4:0] idx_q, idx_d;
  logic [2:0] seg;

  assign seg = seg_at(pos_q);

  always_comb begin
    state_d = state_q;
    pos_d   = pos_q;
    idx_d   = idx_q;
    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          state_d = ST_RD;
          pos_d   = '0;
          idx_d   = '0;
        end
      end
      ST_RD: state_d = ST_EX;
      ST_EX: state_d = ST_WB;
      ST_WB: begin
        state_d = ST_RD;
        if (idx_q == seg_last(seg)) begin
          idx_d = '0;
          if (pos_q == LAST_POS) begin
            state_d = ST_IDLE;
          end else begin
            pos_d = pos_q + 1'b1;
          end
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      pos_q   <= '0;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      pos_q   <= pos_d;
      idx_q   <= idx_d;
    end
  end

  assign idle_o    = (state_q == ST_IDLE);
  assign cmd_o.rd  = (state_q == ST_RD);
  assign cmd_o.ex  = (state_q == ST_EX);
  assign cmd_o.wb  = (state_q == ST_WB);
  assign cmd_o.uop = prog_op(seg, idx_q);

  a_rd_ex: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RD) |=> (state_q == ST_EX)) else $error("read not followed by execute");
  a_ex_wb: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EX) |=> (state_q == ST_WB)) else $error("execute not followed by write");
  a_stay: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE && !start_i) |=> (state_q == ST_IDLE)) else $error("left idle unprompted");
  a_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_WB && pos_q == LAST_POS && idx_q == seg_last(SG_FIN)) |=> idle_o)
    else $error("program did not finish");

endmodule
`default_nettype wire

>>> hdl/aizawa_rk4_integrator_unit.sv
`default_nettype none
// Aizawa attractor point generator, RK4 in signed Q8.24. Each input transfer
// emits the current point (after an optional restart load) and then runs one
// RK4 step as 139 micro-operations on a single shared multiply/add unit, each
// passing through operand read, execute, and round and write back in turn. The
// emitted point is held in an output register; the next item is taken once the
// step has finished and the output register is free or being drained.
// Registers coef_a..coef_f and step_size sit at byte addresses 0x00..0x18.
module aizawa_rk4_integrator_unit import aizrk_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  aizrk_in_if.sink         in_i,
  aizrk_out_if.source      out_o,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  logic signed [31:0] ca_q, cb_q, cc_q, cd_q, ce_q, cf_q;
  logic [24:0]        step_q;
  logic [2:0]         ridx;
  logic               cfg_wr, in_xfer, idle, out_valid_q;
  logic signed [31:0] ox_q, oy_q, oz_q;
  ctrl_cmd_t          cmd;
  coef_t              coef;
  pos_t               pos;

  assign pready = 1'b1;
  assign ridx   = paddr[4:2];
  assign cfg_wr = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ca_q   <= 32'sd15938355;
      cb_q   <= 32'sd11744051;
      cc_q   <= 32'sd10066330;
      cd_q   <= 32'sd58720256;
      ce_q   <= 32'sd4194304;
      cf_q   <= 32'sd1677722;
      step_q <= 25'd167772;
    end else if (cfg_wr) begin
      case (ridx)
        RG_A:    ca_q   <= pwdata;
        RG_B:    cb_q   <= pwdata;
        RG_C:    cc_q   <= pwdata;
        RG_D:    cd_q   <= pwdata;
        RG_E:    ce_q   <= pwdata;
        RG_F:    cf_q   <= pwdata;
        RG_STEP: step_q <= pwdata[24:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (ridx)
      RG_A:    prdata = ca_q;
      RG_B:    prdata = cb_q;
      RG_C:    prdata = cc_q;
      RG_D:    prdata = cd_q;
      RG_E:    prdata = ce_q;
      RG_F:    prdata = cf_q;
      RG_STEP: prdata = {7'd0, step_q};
      default: prdata = '0;
    endcase
  end

  assign coef.a = ca_q;
  assign coef.b = cb_q;
  assign coef.c = cc_q;
  assign coef.d = cd_q;
  assign coef.e = ce_q;
  assign coef.f = cf_q;
  assign coef.h = {7'd0, step_q};

  assign in_i.ready = idle & (~out_valid_q | out_o.ready);
  assign in_xfer    = in_i.valid & in_i.ready;

  aizrk_controller u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (in_xfer),
    .idle_o  (idle),
    .cmd_o   (cmd)
  );

  aizrk_datapath u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (cmd),
    .coef_i    (coef),
    .load_i    (in_xfer & in_i.restart),
    .start_x_i (in_i.start_x),
    .start_y_i (in_i.start_y),
    .start_z_i (in_i.start_z),
    .pos_o     (pos)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_xfer) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  // capture the point before the step
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      ox_q <= in_i.restart ? in_i.start_x : pos.x;
      oy_q <= in_i.restart ? in_i.start_y : pos.y;
      oz_q <= in_i.restart ? in_i.start_z : pos.z;
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.out_x = ox_q;
  assign out_o.out_y = oy_q;
  assign out_o.out_z = oz_q;

endmodule
`default_nettype wire

>>> bench/rk4_checker.sv
module rk4_checker import aizrk_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  aizrk_in_if              in_m,
  aizrk_out_if             out_m,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  input  wire logic        pready,
  output int               fail_count,
  output int               pending
);

  localparam longint ONE   = 64'sd1 <<< 24;
  localparam longint MAXV  = 64'sd2147483647;
  localparam longint MINV  = -64'sd2147483648;
  localparam longint THIRD = (ONE + 1) / 3;
  localparam longint SIXTH = (ONE + 3) / 6;
  localparam longint HALF  = ONE / 2;

  typedef struct {
    longint x;
    longint y;
    longint z;
  } vec_t;

  typedef struct {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
  } point_t;

  longint ca, cb, cc, cd, ce, cf, dt;
  vec_t   pos;
  point_t points_due[$];

  function automatic longint clamp(longint v);
    if (v > MAXV) return MAXV;
    if (v < MINV) return MINV;
    return v;
  endfunction

  // exact product, round half away from zero, saturate
  function automatic longint qmul(longint a, longint b);
    logic        neg;
    logic [63:0] ma, mb, p;
    neg = (a < 0) != (b < 0);
    ma  = a < 0 ? 64'(-a) : 64'(a);
    mb  = b < 0 ? 64'(-b) : 64'(b);
    p   = (ma * mb + 64'd8388608) >> 24;
    if (neg) return p > 64'd2147483648 ? MINV : -longint'(p);
    return p > 64'd2147483647 ? MAXV : longint'(p);
  endfunction

  function automatic vec_t slope(vec_t s);
    vec_t   k;
    longint zb, z3, r2, ez, t;
    zb  = clamp(s.z - cb);
    k.x = clamp(qmul(zb, s.x) - qmul(cd, s.y));
    k.y = clamp(qmul(cd, s.x) + qmul(zb, s.y));
    z3  = qmul(qmul(s.z, s.z), s.z);
    r2  = clamp(qmul(s.x, s.x) + qmul(s.y, s.y));
    ez  = clamp(ONE + qmul(ce, s.z));
    t   = clamp(cc + qmul(ca, s.z));
    t   = clamp(t - qmul(z3, THIRD));
    t   = clamp(t - qmul(r2, ez));
    k.z = clamp(t + qmul(qmul(cf, s.x), s.z));
    return k;
  endfunction

  function automatic vec_t nudge(vec_t s, vec_t k, longint h);
    vec_t r;
    r.x = clamp(s.x + qmul(h, k.x));
    r.y = clamp(s.y + qmul(h, k.y));
    r.z = clamp(s.z + qmul(h, k.z));
    return r;
  endfunction

  function automatic longint blend(longint k1, longint k2, longint k3, longint k4);
    longint t;
    t = clamp(k1 + clamp(k2 + k2));
    t = clamp(t + clamp(k3 + k3));
    return clamp(t + k4);
  endfunction

  task automatic rk4_advance();
    vec_t   k1, k2, k3, k4;
    longint hh, h6;
    hh = qmul(HALF, dt);
    h6 = qmul(dt, SIXTH);
    k1 = slope(pos);
    k2 = slope(nudge(pos, k1, hh));
    k3 = slope(nudge(pos, k2, hh));
    k4 = slope(nudge(pos, k3, dt));
    pos.x = clamp(pos.x + qmul(h6, blend(k1.x, k2.x, k3.x, k4.x)));
    pos.y = clamp(pos.y + qmul(h6, blend(k1.y, k2.y, k3.y, k4.y)));
    pos.z = clamp(pos.z + qmul(h6, blend(k1.z, k2.z, k3.z, k4.z)));
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    point_t p, got;
    longint w;
    if (!rst_ni) begin
      ca = 15938355;
      cb = 11744051;
      cc = 10066330;
      cd = 58720256;
      ce = 4194304;
      cf = 1677722;
      dt = 167772;
      pos.x = 1677722;
      pos.y = 0;
      pos.z = 0;
      points_due.delete();
      fail_count <= 0;
      pending <= 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        w = longint'($signed(pwdata));
        case (paddr[4:2])
          RG_A:    ca = w;
          RG_B:    cb = w;
          RG_C:    cc = w;
          RG_D:    cd = w;
          RG_E:    ce = w;
          RG_F:    cf = w;
          RG_STEP: dt = longint'(pwdata[24:0]);
          default: ;
        endcase
      end
      if (in_m.valid && in_m.ready) begin
        if (in_m.restart) begin
          pos.x = in_m.start_x;
          pos.y = in_m.start_y;
          pos.z = in_m.start_z;
        end
        p.x = 32'(pos.x);
        p.y = 32'(pos.y);
        p.z = 32'(pos.z);
        points_due.push_back(p);
        rk4_advance();
      end
      if (out_m.valid && out_m.ready) begin
        got.x = out_m.out_x;
        got.y = out_m.out_y;
        got.z = out_m.out_z;
        if (points_due.size() == 0) begin
          $display("%0t: unexpected point x=%0d y=%0d z=%0d", $time, got.x, got.y, got.z);
          fail_count <= fail_count + 1;
        end else begin
          p = points_due.pop_front();
          if (p.x !== got.x || p.y !== got.y || p.z !== got.z) begin
            $display("%0t: point mismatch expected x=%0d y=%0d z=%0d actual x=%0d y=%0d z=%0d",
                     $time, p.x, p.y, p.z, got.x, got.y, got.z);
            fail_count <= fail_count + 1;
          end
        end
      end
      pending <= points_due.size();
    end
  end

endmodule

>>> bench/testbench.sv
module testbench;
  import aizrk_pkg::*;

  localparam int STEP_CYCLES = 450;
  localparam int IDLE_LIMIT  = 8000;
  localparam int HOLD_CYCLES = 1500;
  localparam int PHASE_ITEMS = 240;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        psel, penable, pwrite;
  logic [4:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  int          fail_count, pending;
  int          idle_cycles;
  int          rx_count;

  aizrk_in_if  pt_in();
  aizrk_out_if pt_out();

  aizawa_rk4_integrator_unit uut (
    .clk_i(clk), .rst_ni(rst_n), .in_i(pt_in), .out_o(pt_out),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  rk4_checker chk (
    .clk_i(clk), .rst_ni(rst_n), .in_m(pt_in), .out_m(pt_out),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .pready(pready), .fail_count(fail_count), .pending(pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // watchdog: cycles in which no transfer happens on either channel
  always @(posedge clk) begin
    if ((pt_in.valid && pt_in.ready) || (pt_out.valid && pt_out.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles > IDLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic reg_write(logic [2:0] idx, logic [31:0] val);
    @(posedge clk);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic load_coefs(int a, int b, int c, int d, int e, int f, int h);
    reg_write(RG_A, a);
    reg_write(RG_B, b);
    reg_write(RG_C, c);
    reg_write(RG_D, d);
    reg_write(RG_E, e);
    reg_write(RG_F, f);
    reg_write(RG_STEP, h);
  endtask

  task automatic send_tick(logic rs, int sx, int sy, int sz);
    int gap;
    gap = $urandom_range(0, 9);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      pt_in.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    pt_in.valid <= 1'b1;
    pt_in.restart <= rs;
    pt_in.start_x <= sx;
    pt_in.start_y <= sy;
    pt_in.start_z <= sz;
    do @(posedge clk); while (!pt_in.ready);
  endtask

  function automatic int near_value();
    if ($urandom_range(0, 3) == 0) return int'($urandom);
    return int'($urandom_range(0, 67108864)) - 33554432;
  endfunction

  task automatic random_tick();
    send_tick($urandom_range(0, 19) == 0, near_value(), near_value(), near_value());
  endtask

  task automatic drain();
    pt_in.valid <= 1'b0;
    wait (pending == 0);
    repeat (STEP_CYCLES) @(posedge clk);
  endtask

  // receiver: random stalls, one long hold-off so the block backs up
  initial begin
    int gap;
    bit held;
    held = 0;
    rx_count = 0;
    pt_out.ready <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      gap = $urandom_range(0, 9);
      if ($urandom_range(0, 3) == 0) gap = 0;
      if (!held && rx_count == 300) begin
        held = 1;
        gap = HOLD_CYCLES;
      end
      if (gap > 0) begin
        pt_out.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      pt_out.ready <= 1'b1;
      do @(posedge clk); while (!pt_out.valid);
      rx_count++;
    end
  end

  initial begin
    int h;
    rst_n <= 1'b0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    pt_in.valid <= 1'b0;
    pt_in.restart <= 1'b0;
    pt_in.start_x <= '0;
    pt_in.start_y <= '0;
    pt_in.start_z <= '0;
    idle_cycles <= 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // directed: reset position, extreme starts, stepping from each
    send_tick(1'b0, 0, 0, 0);
    send_tick(1'b0, -1, -1, -1);
    send_tick(1'b1, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff);
    send_tick(1'b0, 0, 0, 0);
    send_tick(1'b1, 32'sh80000000, 32'sh80000000, 32'sh80000000);
    send_tick(1'b0, 0, 0, 0);
    send_tick(1'b1, 0, 0, 0);
    send_tick(1'b0, 0, 0, 0);
    send_tick(1'b1, -1, -1, -1);
    send_tick(1'b0, 0, 0, 0);
    send_tick(1'b1, 32'sh7fffffff, 32'sh80000000, 0);
    send_tick(1'b0, 0, 0, 0);
    send_tick(1'b1, 1677722, 0, 0);
    repeat (6) send_tick(1'b0, 0, 0, 0);
    send_tick(1'b1, 16777216, -16777216, 33554432);
    send_tick(1'b0, 0, 0, 0);
    drain();

    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: load_coefs(15938355, 11744051, 10066330, 58720256, 4194304, 1677722, 167772);
        1: begin
          load_coefs(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                     32'h7fffffff, 32'h7fffffff, 1);
          reg_write(3'd7, 32'hffffffff);
        end
        2: load_coefs(32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000,
                      32'h80000000, 32'h80000000, 16777216);
        3: load_coefs(15938355, 11744051, 10066330, 58720256, 4194304, 1677722, 16777216);
        4: load_coefs(15938355, 11744051, 10066330, 58720256, 4194304, 1677722, 1);
        default: begin
          h = $urandom_range(1, 1 << 20);
          load_coefs(15938355 + int'($urandom_range(0, 4194304)) - 2097152,
                     11744051 + int'($urandom_range(0, 4194304)) - 2097152,
                     10066330 + int'($urandom_range(0, 4194304)) - 2097152,
                     58720256 + int'($urandom_range(0, 8388608)) - 4194304,
                     int'($urandom),
                     1677722 + int'($urandom_range(0, 4194304)) - 2097152,
                     h);
        end
      endcase
      send_tick(1'b1, 1677722, 0, 0);
      repeat (PHASE_ITEMS - 1) random_tick();
      drain();
    end

    if (fail_count == 0 && pending == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

>>> sim.f
hdl/aizrk_pkg.sv
hdl/aizrk_if.sv
hdl/aizrk_datapath.sv
hdl/aizrk_controller.sv
hdl/aizawa_rk4_integrator_unit.sv
bench/rk4_checker.sv
bench/testbench.sv
